// ===== rtl/fjop_pkg.sv =====
// Shared types, character constants and decode helpers for the flat JSON object parser.
package fjop_pkg;

   // Default depth of the job queue between parser front and result back end
   localparam int QUEUE_DEPTH = 4;

   // Parser phases
   typedef enum logic [4:0] {
      PH_OPEN       = 5'd0,
      PH_AFTER_OPEN = 5'd1,
      PH_STRING     = 5'd2,
      PH_ESCAPE     = 5'd3,
      PH_HEX1       = 5'd4,
      PH_SURR_BS    = 5'd5,
      PH_SURR_U     = 5'd6,
      PH_HEX2       = 5'd7,
      PH_AFTER_KEY  = 5'd8,
      PH_BEFORE_VAL = 5'd9,
      PH_NULL       = 5'd10,
      PH_AFTER_VAL  = 5'd11,
      PH_EXPECT_KEY = 5'd12,
      PH_CLOSED     = 5'd13
   } phase_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_KEY_BYTE   = 3'd0,
      KIND_VALUE_BYTE = 3'd1,
      KIND_KEY_END    = 3'd2,
      KIND_STRING_END = 3'd3,
      KIND_NULL       = 3'd4,
      KIND_ACCEPTED   = 3'd5,
      KIND_REJECTED   = 3'd6
   } kind_type;

   // Everything one input byte produces: decoded bytes, then a marker, then a verdict
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      nbytes;
      logic            data_key;
      logic            mark_en;
      kind_type        mark_kind;
      logic            verd_en;
      kind_type        verd_kind;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      n;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] val;
   } esc_type;

   // Characters
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_L  = 8'h6c;

   // Code point limits
   localparam logic [15:0] SURR_HIGH_LO = 16'hd800;
   localparam logic [15:0] SURR_HIGH_HI = 16'hdbff;
   localparam logic [15:0] SURR_LOW_LO  = 16'hdc00;
   localparam logic [15:0] SURR_LOW_HI  = 16'hdfff;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [20:0] UTF8_MAX1    = 21'h7f;
   localparam logic [20:0] UTF8_MAX2    = 21'h7ff;
   localparam logic [20:0] UTF8_MAX3    = 21'hffff;

   // C-locale whitespace
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
   endfunction

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type    r;
      logic [7:0] d;
      r = '0;
      d = '0;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         r.ok = 1'b1;
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
         r.ok = 1'b1;
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
         r.ok = 1'b1;
      end
      r.val = d[3:0];
      return r;
   endfunction

   // Single-character escapes (not \u)
   function automatic esc_type escape_map(input logic [7:0] c);
      esc_type r;
      r = '0;
      r.ok = 1'b1;
      case (c)
         CH_QUOTE, CH_BSLASH, CH_SLASH: r.val = c;
         CH_LOW_B: r.val = 8'h08;
         CH_LOW_F: r.val = 8'h0c;
         CH_LOW_N: r.val = 8'h0a;
         CH_LOW_R: r.val = 8'h0d;
         CH_LOW_T: r.val = 8'h09;
         default:  r.ok = 1'b0;
      endcase
      return r;
   endfunction

   // UTF-8 encoder, first byte in data[0]
   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= UTF8_MAX1) begin
         r.data[0] = cp[7:0];
         r.n = 3'd1;
      end else if (cp <= UTF8_MAX2) begin
         r.data[0] = {3'b110, cp[10:6]};
         r.data[1] = {2'b10, cp[5:0]};
         r.n = 3'd2;
      end else if (cp <= UTF8_MAX3) begin
         r.data[0] = {4'b1110, cp[15:12]};
         r.data[1] = {2'b10, cp[11:6]};
         r.data[2] = {2'b10, cp[5:0]};
         r.n = 3'd3;
      end else begin
         r.data[0] = {5'b11110, cp[20:18]};
         r.data[1] = {2'b10, cp[17:12]};
         r.data[2] = {2'b10, cp[11:6]};
         r.data[3] = {2'b10, cp[5:0]};
         r.n = 3'd4;
      end
      return r;
   endfunction

endpackage

// ===== rtl/fjop_front.sv =====
// Parser front: takes one byte a cycle while in_accept is high, tracks the grammar and builds a result job.
module fjop_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output fjop_pkg::job_type job,
   output logic              job_push
);

   fjop_pkg::phase_type phase_ff, phase_in;
   logic        in_key_ff, in_key_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [9:0]  high_surr_ff, high_surr_in;
   logic [1:0]  null_match_ff, null_match_in;
   logic        failed_ff;
   logic        err;

   fjop_pkg::hex_type  hx;
   fjop_pkg::esc_type  esc;
   fjop_pkg::utf8_type enc_bmp, enc_supp;
   logic [15:0] hex_new;
   logic        is_high, is_low, sp;
   logic [20:0] cp_supp;
   logic [7:0]  null_want;

   // Shared decode of the current byte
   assign hx        = fjop_pkg::hex_digit(in_byte);
   assign esc       = fjop_pkg::escape_map(in_byte);
   assign sp        = fjop_pkg::is_space(in_byte);
   assign hex_new   = {hex_value_ff[11:0], hx.val};
   assign is_high   = (hex_new >= fjop_pkg::SURR_HIGH_LO) && (hex_new <= fjop_pkg::SURR_HIGH_HI);
   assign is_low    = (hex_new >= fjop_pkg::SURR_LOW_LO) && (hex_new <= fjop_pkg::SURR_LOW_HI);
   assign cp_supp   = fjop_pkg::SUPP_BASE + {1'b0, high_surr_ff, hex_new[9:0]};
   assign enc_bmp   = fjop_pkg::utf8_encode({5'b0, hex_new});
   assign enc_supp  = fjop_pkg::utf8_encode(cp_supp);
   assign null_want = (null_match_ff == 2'd1) ? fjop_pkg::CH_LOW_U : fjop_pkg::CH_LOW_L;

   // Next state and grammar check
   always_comb begin
      phase_in      = phase_ff;
      in_key_in     = in_key_ff;
      hex_value_in  = hex_value_ff;
      hex_count_in  = hex_count_ff;
      high_surr_in  = high_surr_ff;
      null_match_in = null_match_ff;
      err           = 1'b0;
      case (phase_ff)
         fjop_pkg::PH_OPEN: begin
            if (in_byte == fjop_pkg::CH_LBRACE) phase_in = fjop_pkg::PH_AFTER_OPEN;
            else if (!sp) err = 1'b1;
         end
         fjop_pkg::PH_AFTER_OPEN: begin
            if (in_byte == fjop_pkg::CH_RBRACE) begin
               phase_in = fjop_pkg::PH_CLOSED;
            end else if (in_byte == fjop_pkg::CH_QUOTE) begin
               in_key_in = 1'b1;
               phase_in  = fjop_pkg::PH_STRING;
            end else if (!sp) begin
               err = 1'b1;
            end
         end
         fjop_pkg::PH_EXPECT_KEY: begin
            if (in_byte == fjop_pkg::CH_QUOTE) begin
               in_key_in = 1'b1;
               phase_in  = fjop_pkg::PH_STRING;
            end else if (!sp) begin
               err = 1'b1;
            end
         end
         fjop_pkg::PH_STRING: begin
            if (in_byte == fjop_pkg::CH_QUOTE) begin
               phase_in = in_key_ff ? fjop_pkg::PH_AFTER_KEY : fjop_pkg::PH_AFTER_VAL;
            end else if (in_byte == fjop_pkg::CH_BSLASH) begin
               phase_in = fjop_pkg::PH_ESCAPE;
            end else if (in_byte < fjop_pkg::CH_SPACE) begin
               err = 1'b1;
            end
         end
         fjop_pkg::PH_ESCAPE: begin
            phase_in = fjop_pkg::PH_STRING;
            if (!esc.ok) begin
               if (in_byte == fjop_pkg::CH_LOW_U) begin
                  hex_value_in = '0;
                  hex_count_in = '0;
                  phase_in     = fjop_pkg::PH_HEX1;
               end else begin
                  err = 1'b1;
               end
            end
         end
         fjop_pkg::PH_HEX1: begin
            if (!hx.ok) begin
               err = 1'b1;
            end else begin
               hex_value_in = hex_new;
               if (hex_count_ff != 2'd3) begin
                  hex_count_in = hex_count_ff + 2'd1;
               end else begin
                  hex_count_in = '0;
                  if (is_high) begin
                     high_surr_in = hex_new[9:0];
                     phase_in     = fjop_pkg::PH_SURR_BS;
                  end else if (is_low) begin
                     err = 1'b1;
                  end else begin
                     phase_in = fjop_pkg::PH_STRING;
                  end
               end
            end
         end
         fjop_pkg::PH_SURR_BS: begin
            if (in_byte == fjop_pkg::CH_BSLASH) phase_in = fjop_pkg::PH_SURR_U;
            else err = 1'b1;
         end
         fjop_pkg::PH_SURR_U: begin
            if (in_byte == fjop_pkg::CH_LOW_U) begin
               hex_value_in = '0;
               hex_count_in = '0;
               phase_in     = fjop_pkg::PH_HEX2;
            end else begin
               err = 1'b1;
            end
         end
         fjop_pkg::PH_HEX2: begin
            if (!hx.ok) begin
               err = 1'b1;
            end else begin
               hex_value_in = hex_new;
               if (hex_count_ff != 2'd3) begin
                  hex_count_in = hex_count_ff + 2'd1;
               end else begin
                  hex_count_in = '0;
                  if (is_low) phase_in = fjop_pkg::PH_STRING;
                  else err = 1'b1;
               end
            end
         end
         fjop_pkg::PH_AFTER_KEY: begin
            if (in_byte == fjop_pkg::CH_COLON) phase_in = fjop_pkg::PH_BEFORE_VAL;
            else if (!sp) err = 1'b1;
         end
         fjop_pkg::PH_BEFORE_VAL: begin
            if (in_byte == fjop_pkg::CH_QUOTE) begin
               in_key_in = 1'b0;
               phase_in  = fjop_pkg::PH_STRING;
            end else if (in_byte == fjop_pkg::CH_LOW_N) begin
               null_match_in = 2'd1;
               phase_in      = fjop_pkg::PH_NULL;
            end else if (!sp) begin
               err = 1'b1;
            end
         end
         fjop_pkg::PH_NULL: begin
            if (in_byte != null_want) begin
               err = 1'b1;
            end else if (null_match_ff != 2'd3) begin
               null_match_in = null_match_ff + 2'd1;
            end else begin
               null_match_in = '0;
               phase_in      = fjop_pkg::PH_AFTER_VAL;
            end
         end
         fjop_pkg::PH_AFTER_VAL: begin
            if (in_byte == fjop_pkg::CH_COMMA) phase_in = fjop_pkg::PH_EXPECT_KEY;
            else if (in_byte == fjop_pkg::CH_RBRACE) phase_in = fjop_pkg::PH_CLOSED;
            else if (!sp) err = 1'b1;
         end
         fjop_pkg::PH_CLOSED: begin
            if (!sp) err = 1'b1;
         end
         default: err = 1'b1;
      endcase
   end

   // Job contents: decoded bytes, end marker, verdict
   always_comb begin
      job          = '0;
      job.data_key = in_key_ff;
      case (phase_ff)
         fjop_pkg::PH_STRING: begin
            if (in_byte == fjop_pkg::CH_QUOTE) begin
               job.mark_en   = 1'b1;
               job.mark_kind = in_key_ff ? fjop_pkg::KIND_KEY_END : fjop_pkg::KIND_STRING_END;
            end else if (in_byte != fjop_pkg::CH_BSLASH && in_byte >= fjop_pkg::CH_SPACE) begin
               job.data[0] = in_byte;
               job.nbytes  = 3'd1;
            end
         end
         fjop_pkg::PH_ESCAPE: begin
            if (esc.ok) begin
               job.data[0] = esc.val;
               job.nbytes  = 3'd1;
            end
         end
         fjop_pkg::PH_HEX1: begin
            if (hx.ok && hex_count_ff == 2'd3 && !is_high && !is_low) begin
               job.data   = enc_bmp.data;
               job.nbytes = enc_bmp.n;
            end
         end
         fjop_pkg::PH_HEX2: begin
            if (hx.ok && hex_count_ff == 2'd3 && is_low) begin
               job.data   = enc_supp.data;
               job.nbytes = enc_supp.n;
            end
         end
         fjop_pkg::PH_NULL: begin
            if (in_byte == null_want && null_match_ff == 2'd3) begin
               job.mark_en   = 1'b1;
               job.mark_kind = fjop_pkg::KIND_NULL;
            end
         end
         default: begin
            job.nbytes = '0;
         end
      endcase
      if (err) begin
         job.nbytes    = '0;
         job.mark_en   = 1'b0;
         job.verd_en   = 1'b1;
         job.verd_kind = fjop_pkg::KIND_REJECTED;
      end else if (in_last) begin
         job.verd_en   = 1'b1;
         job.verd_kind = (phase_in == fjop_pkg::PH_CLOSED) ? fjop_pkg::KIND_ACCEPTED
                                                           : fjop_pkg::KIND_REJECTED;
      end
   end

   assign job_push = in_accept && !failed_ff && (job.nbytes != '0 || job.mark_en || job.verd_en);

   // Parser state; the last byte of a text rearms everything
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= fjop_pkg::PH_OPEN;
         in_key_ff     <= 1'b0;
         hex_value_ff  <= '0;
         hex_count_ff  <= '0;
         high_surr_ff  <= '0;
         null_match_ff <= '0;
         failed_ff     <= 1'b0;
      end else if (in_accept) begin
         if (in_last) begin
            phase_ff      <= fjop_pkg::PH_OPEN;
            in_key_ff     <= 1'b0;
            hex_value_ff  <= '0;
            hex_count_ff  <= '0;
            high_surr_ff  <= '0;
            null_match_ff <= '0;
            failed_ff     <= 1'b0;
         end else if (!failed_ff) begin
            if (err) begin
               failed_ff <= 1'b1;
            end else begin
               phase_ff      <= phase_in;
               in_key_ff     <= in_key_in;
               hex_value_ff  <= hex_value_in;
               hex_count_ff  <= hex_count_in;
               high_surr_ff  <= high_surr_in;
               null_match_ff <= null_match_in;
            end
         end
      end
   end

endmodule

// ===== rtl/fjop_queue.sv =====
// Short job queue that decouples the parser front from the result back end.
module fjop_queue #(
   parameter int DEPTH = fjop_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fjop_pkg::job_type         push_data,
   input  logic                      pop,
   output fjop_pkg::job_type         pop_data,
   output fjop_pkg::queue_status_type status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   fjop_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) count_ff <= count_ff + CW'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CW'(1);
      end
   end

endmodule

// ===== rtl/fjop_back.sv =====
// Result back end: plays out one job as a run of result transfers.
module fjop_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fjop_pkg::job_type          q_data,
   input  fjop_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   fjop_pkg::job_type job_ff;
   logic              job_valid_ff;
   logic [2:0]        idx_ff;
   logic [2:0]        total;
   logic              last_item, fire;
   fjop_pkg::kind_type kind;

   assign total     = job_ff.nbytes + {2'b0, job_ff.mark_en} + {2'b0, job_ff.verd_en};
   assign last_item = (idx_ff == total - 3'd1);
   assign fire      = rsp_tvalid && rsp_tready;
   assign q_pop     = !q_status.empty && (!job_valid_ff || (fire && last_item));

   // Pick the current item: data bytes, then marker, then verdict
   always_comb begin
      rsp_tdata = '0;
      if (idx_ff < job_ff.nbytes) begin
         rsp_tdata = job_ff.data[idx_ff[1:0]];
         kind = job_ff.data_key ? fjop_pkg::KIND_KEY_BYTE : fjop_pkg::KIND_VALUE_BYTE;
      end else if (job_ff.mark_en && idx_ff == job_ff.nbytes) begin
         kind = job_ff.mark_kind;
      end else begin
         kind = job_ff.verd_kind;
      end
   end

   assign rsp_tvalid = job_valid_ff;
   assign rsp_tuser  = kind;
   assign rsp_tlast  = last_item;

   // Current job and item index
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (q_pop) begin
         job_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (fire) begin
         if (last_item) job_valid_ff <= 1'b0;
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_data;
   end

endmodule

// ===== rtl/flat_json_object_parser.sv =====
// Top level of the flat JSON object parser: front, job queue and back end.
//
// Usage: feed one byte of JSON text per transfer on req_ (tdata = byte, tlast
// marks the final byte of the text). The block checks that the text is a flat
// object whose values are strings or null and streams results on rsp_: decoded
// key/value bytes, key end, string end, null, and one accept/reject verdict per
// text (tuser = kind, tlast = last result caused by that input byte).
// After the first error a reject is sent and bytes are dropped until the last
// byte of the text, which rearms the parser.
// A byte's results pass a queue entry and the back end job register. Throughput:
// one byte per cycle while each byte gives at most one result and rsp_tready is
// high; a byte giving n results (up to five, e.g. a \u surrogate pair as four
// UTF-8 bytes plus a verdict) holds rsp_ until all are sent. The job queue
// (QUEUE_DEPTH entries) absorbs this; req_tready drops only when it is full.
// Reset clears the parser, the queue and the output stage; no result is
// pending afterward. When the receiver stalls, the current result holds and
// the queue fills, then req_tready goes low until room frees up.
module flat_json_object_parser #(
   parameter int QUEUE_DEPTH = fjop_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [2:0] out_kind
   output logic       rsp_tlast
);

   fjop_pkg::job_type          job, q_data;
   fjop_pkg::queue_status_type q_status;
   logic                       job_push, q_pop, req_accept;

   assign req_tready = !q_status.full;
   assign req_accept = req_tvalid && req_tready;

   fjop_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .job       (job),
      .job_push  (job_push)
   );

   fjop_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   fjop_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (q_data),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A job is never pushed into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_status.full) else $error("job pushed into full queue");

   // Marker and verdict results carry a zero byte
   a_ctrl_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != fjop_pkg::KIND_KEY_BYTE
                  && rsp_tuser != fjop_pkg::KIND_VALUE_BYTE) |-> rsp_tdata == 8'h00)
      else $error("nonzero byte on marker result");

   // Nothing is pending right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result valid after reset");

endmodule
